// File: rtl/sqd_pkg.sv
package sqd_pkg;

    // coordinate and lane geometry
    localparam int COORD_BITS = 16;
    localparam int NUM_A      = 4;
    localparam int NUM_B      = 4;
    localparam int ACC_BITS   = 48;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int COL_BITS   = $clog2(NUM_B);

    // stream widths
    localparam int S_DATA_BITS = (NUM_A + NUM_B) * COORD_BITS;
    localparam int M_DATA_BITS = NUM_A * ACC_BITS;

    // index of the final column of a tile
    localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(NUM_B - 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef logic [ACC_BITS-1:0]          acc_t;
    typedef acc_t                         col_sums_t [NUM_A];

    // per-cycle control from the top level to every lane
    typedef struct packed {
        logic adv;      // pipeline moves this cycle
        logic acc_en;   // squares in stage two are summed in
        logic acc_clr;  // tile ends: accumulators restart from zero
    } lane_ctrl_t;

    // saturating add of one square into an accumulator
    function automatic acc_t sat_add(input acc_t acc, input sq_t sq);
        logic [ACC_BITS:0] sum;
        begin
            sum = {1'b0, acc} + {(ACC_BITS + 1 - SQ_BITS)'(0), sq};
            sat_add = sum[ACC_BITS] ? {ACC_BITS{1'b1}} : sum[ACC_BITS-1:0];
        end
    endfunction

endpackage

// File: rtl/sqd_lane.sv
module sqd_lane
    import sqd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  coord_t     a [NUM_A],
    input  coord_t     b,
    output col_sums_t  sums
);

    diff_t                         diff_reg [NUM_A];
    logic signed [2*DIFF_BITS-1:0] prod     [NUM_A];
    sq_t                           sq_reg   [NUM_A];
    acc_t                          acc_reg  [NUM_A];
    acc_t                          acc_next [NUM_A];

    // stage one: exact differences against this lane's b point
    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            for (int i = 0; i < NUM_A; i++)
            begin
                diff_reg[i] <= diff_t'(a[i]) - diff_t'(b);
            end
        end
    end

    // full-width signed products, the square always fits in the low bits
    always_comb
    begin
        for (int i = 0; i < NUM_A; i++)
        begin
            prod[i] = diff_reg[i] * diff_reg[i];
        end
    end

    // stage two: squares, one multiplier per pair
    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            for (int i = 0; i < NUM_A; i++)
            begin
                sq_reg[i] <= prod[i][SQ_BITS-1:0];
            end
        end
    end

    // saturating sums, also handed to the merge stage at tile end
    always_comb
    begin
        for (int i = 0; i < NUM_A; i++)
        begin
            acc_next[i] = sat_add(acc_reg[i], sq_reg[i]);
            sums[i]     = acc_next[i];
        end
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_A; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.acc_en)
        begin
            for (int i = 0; i < NUM_A; i++)
            begin
                acc_reg[i] <= ctrl.acc_clr ? '0 : acc_next[i];
            end
        end
    end

endmodule

// File: rtl/sqd_merge.sv
module sqd_merge
    import sqd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   snap,
    input  col_sums_t              sums [NUM_B],
    output logic                   full,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_DATA_BITS-1:0] m_axis_tdata,
    output logic [COL_BITS-1:0]    m_axis_tuser,
    output logic                   m_axis_tlast
);

    acc_t                bank_reg [2][NUM_B][NUM_A];
    logic [1:0]          bank_valid_reg, bank_valid_next;
    logic                wr_sel_reg, wr_sel_next;
    logic                rd_sel_reg, rd_sel_next;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic                pop;
    logic                pop_last;

    // capture a finished tile into the free bank
    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            for (int j = 0; j < NUM_B; j++)
            begin
                for (int i = 0; i < NUM_A; i++)
                begin
                    bank_reg[wr_sel_reg][j][i] <= sums[j][i];
                end
            end
        end
    end

    // bank bookkeeping and column sequencing
    always_comb
    begin
        pop             = m_axis_tvalid && m_axis_tready;
        pop_last        = pop && (col_reg == LAST_COL);
        bank_valid_next = bank_valid_reg;
        wr_sel_next     = wr_sel_reg;
        rd_sel_next     = rd_sel_reg;
        col_next        = col_reg;
        if (snap)
        begin
            bank_valid_next[wr_sel_reg] = 1'b1;
            wr_sel_next                 = ~wr_sel_reg;
        end
        if (pop)
        begin
            col_next = col_reg + COL_BITS'(1);
        end
        if (pop_last)
        begin
            bank_valid_next[rd_sel_reg] = 1'b0;
            rd_sel_next                 = ~rd_sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_valid_reg <= '0;
            wr_sel_reg     <= 1'b0;
            rd_sel_reg     <= 1'b0;
            col_reg        <= '0;
        end
        else
        begin
            bank_valid_reg <= bank_valid_next;
            wr_sel_reg     <= wr_sel_next;
            rd_sel_reg     <= rd_sel_next;
            col_reg        <= col_next;
        end
    end

    // output beat straight from the draining bank
    always_comb
    begin
        full          = bank_valid_reg[wr_sel_reg];
        m_axis_tvalid = bank_valid_reg[rd_sel_reg];
        m_axis_tuser  = col_reg;
        m_axis_tlast  = (col_reg == LAST_COL);
        for (int i = 0; i < NUM_A; i++)
        begin
            m_axis_tdata[i*ACC_BITS +: ACC_BITS] = bank_reg[rd_sel_reg][col_reg][i];
        end
    end

endmodule

// File: rtl/squared_distance_tile_4x4.sv
// channel    | dir | signals                     | contents
// -----------+-----+-----------------------------+------------------------------------------
// s_axis     | in  | tvalid tready tdata tlast   | one dimension: a_0..a_3, b_0..b_3; tlast = last_dim
// m_axis     | out | tvalid tready tdata tuser   | one column: dist_0..dist_3; tuser = column;
//            |     | tlast                       | tlast = last_column
//
// one beat per cycle in while s_axis_tready is high; the lanes run a three step pipeline
// (difference, square, sum); a tile's four result beats are banked when its last beat is summed
// and leave at one per cycle, while m_axis_tready is high, from a ping-pong pair of result banks
// s_axis_tready drops only while both result banks hold tiles not yet drained
// reset clears accumulators, pipeline valids and the result bank valid flags
module squared_distance_tile_4x4
    import sqd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // a_0, a_1, a_2, a_3, b_0, b_1, b_2, b_3 from bit 0 up
    input  logic [S_DATA_BITS-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // dist_0, dist_1, dist_2, dist_3 from bit 0 up
    output logic [M_DATA_BITS-1:0] m_axis_tdata,
    // column
    output logic [COL_BITS-1:0]    m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic       v1_reg, l1_reg;
    logic       v2_reg, l2_reg;
    logic       adv;
    logic       full;
    lane_ctrl_t ctrl;
    coord_t     a_in [NUM_A];
    coord_t     b_in [NUM_B];
    col_sums_t  sums [NUM_B];

    // unpack coordinates
    always_comb
    begin
        for (int i = 0; i < NUM_A; i++)
        begin
            a_in[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
        end
        for (int j = 0; j < NUM_B; j++)
        begin
            b_in[j] = s_axis_tdata[(NUM_A + j)*COORD_BITS +: COORD_BITS];
        end
    end

    // hold the pipeline only when a tile end finds no free bank
    always_comb
    begin
        adv           = !(v2_reg && l2_reg && full);
        s_axis_tready = adv;
        ctrl.adv      = adv;
        ctrl.acc_en   = adv && v2_reg;
        ctrl.acc_clr  = adv && v2_reg && l2_reg;
    end

    // valid and last through the lane pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            l1_reg <= 1'b0;
            v2_reg <= 1'b0;
            l2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            l1_reg <= s_axis_tlast;
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
        end
    end

    // one lane per b point
    for (genvar j = 0; j < NUM_B; j++)
    begin : g_lane
        sqd_lane u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .ctrl (ctrl),
            .a    (a_in),
            .b    (b_in[j]),
            .sums (sums[j])
        );
    end

    // result banks and column output
    sqd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap         (ctrl.acc_clr),
        .sums         (sums),
        .full         (full),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

// File: rtl/sqd_checker.sv
module sqd_checker
    import sqd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [S_DATA_BITS-1:0] s_axis_tdata,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [M_DATA_BITS-1:0] m_axis_tdata,
    input logic [COL_BITS-1:0]    m_axis_tuser,
    input logic                   m_axis_tlast
);

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // columns of a tile follow one another without a gap
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + COL_BITS'(1)))
        else $error("column sequence broken");

    // tlast marks exactly the final column
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_COL)))
        else $error("tlast not on final column");

    // input stalls only while results are waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind squared_distance_tile_4x4 sqd_checker u_sqd_checker (.*);
